@@ hdl/skst_pkg.sv @@
package skst_pkg;

    // Operation codes
    typedef enum logic [1:0] {
        OP_FIND_ADD   = 2'd0,
        OP_DEACTIVATE = 2'd1,
        OP_EMPTY      = 2'd2,
        OP_NONE       = 2'd3
    } op_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_UPDATED  = 2'd1,
        ST_FULL     = 2'd2,
        ST_BULK     = 2'd3
    } status_t;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_CMP,
        S_SH_RD,
        S_SH_WR,
        S_PUT,
        S_CLR,
        S_DONE
    } state_t;

    localparam int HANDLE_W   = 48;
    localparam int RIDX_W     = 16;
    localparam int SLOT_W     = 8;
    localparam int TOTAL_W    = 9;

endpackage

@@ hdl/sorted_key_table_stable_slots.sv @@
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid / in_ready  | operation, key, function_handle, run_index
// out     | output    | out_valid / out_ready| status, slot, entry_total
//
// One item at a time. Each binary search step reads the middle key, then compares it;
// a miss in a table that is not full moves each key above the insert point up by one
// with a shift read and a shift write in the key memory, then writes the new key.
// Empty and the unused operation go straight to the result.
// Deactivate sweeps the slot memory, one entry a cycle.
// Reset clears the state, the key count and the output valid; memories hold no reset. A
// stalled result sits in the output register; the next item is taken once the sequencer is back in idle.
module sorted_key_table_stable_slots
    import skst_pkg::*;
#(
    parameter int MAX_ENTRIES = 256,
    parameter int KEY_BITS    = 48
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          operation,
    input  logic [KEY_BITS-1:0] key,
    input  logic [HANDLE_W-1:0] function_handle,
    input  logic [RIDX_W-1:0]   run_index,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [1:0]          status,
    output logic [SLOT_W-1:0]   slot,
    output logic [TOTAL_W-1:0]  entry_total
);

    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int KW = KEY_BITS + IW;
    localparam int DW = HANDLE_W + RIDX_W;
    localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_ENTRIES);

    // Memories: sorted keys with their slot numbers, and per-slot data
    logic [KW-1:0] kmem [MAX_ENTRIES];
    logic [DW-1:0] dmem [MAX_ENTRIES];

    state_t state_reg, state_next;

    logic [CW-1:0]       count_reg, count_next;
    logic [CW-1:0]       lo_reg, lo_next;
    logic [CW-1:0]       hi_reg, hi_next;
    logic [CW-1:0]       mid_reg, mid_next;
    logic [CW-1:0]       idx_reg, idx_next;
    logic [KEY_BITS-1:0] key_reg;
    logic [DW-1:0]       data_reg;
    status_t             res_status_reg, res_status_next;
    logic [CW-1:0]       res_slot_reg, res_slot_next;

    logic                out_valid_reg, out_valid_next;
    logic [1:0]          out_status_reg;
    logic [SLOT_W-1:0]   out_slot_reg;
    logic [TOTAL_W-1:0]  out_total_reg;

    logic [KW-1:0]       rdata_reg;
    logic [IW-1:0]       raddr;
    logic                kwe;
    logic [IW-1:0]       kwaddr;
    logic [KW-1:0]       kwdata;
    logic                dwe;
    logic [IW-1:0]       dwaddr;
    logic [DW-1:0]       dwdata;

    logic                accept;
    logic                load_out;
    logic [KEY_BITS-1:0] rkey;
    logic [IW-1:0]       rslot;
    logic [CW-1:0]       mid_calc;
    logic [31:0]         slot_wide;
    logic [31:0]         total_wide;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign load_out = (state_reg == S_DONE) && (!out_valid_reg || out_ready);
    assign rkey     = rdata_reg[KW-1:IW];
    assign rslot    = rdata_reg[IW-1:0];
    assign mid_calc = lo_reg + ((hi_reg - lo_reg) >> 1);

    // Key memory: one read port, one write port
    always_ff @(posedge clk)
    begin
        if (kwe)
        begin
            kmem[kwaddr] <= kwdata;
        end
        rdata_reg <= kmem[raddr];
    end

    // Slot data memory: write only
    always_ff @(posedge clk)
    begin
        if (dwe)
        begin
            dmem[dwaddr] <= dwdata;
        end
    end

    // Captured item
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_reg  <= key;
            data_reg <= {function_handle, run_index};
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        mid_reg        <= mid_next;
        idx_reg        <= idx_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        if (load_out)
        begin
            out_status_reg <= res_status_reg;
            out_slot_reg   <= slot_wide[SLOT_W-1:0];
            out_total_reg  <= total_wide[TOTAL_W-1:0];
        end
    end

    assign slot_wide  = 32'(res_slot_reg);
    assign total_wide = 32'(count_reg);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (op_t'(operation))
                        OP_FIND_ADD:   state_next = S_RD;
                        OP_DEACTIVATE: state_next = S_CLR;
                        OP_EMPTY:      state_next = S_DONE;
                        OP_NONE:       state_next = S_DONE;
                        default:       state_next = S_DONE;
                    endcase
                end
            end
            S_RD:
            begin
                if (lo_reg < hi_reg)
                    state_next = S_CMP;
                else if (count_reg >= FULL_COUNT)
                    state_next = S_DONE;
                else
                    state_next = S_SH_RD;
            end
            S_CMP:
            begin
                if (key_reg == rkey)
                    state_next = S_DONE;
                else
                    state_next = S_RD;
            end
            S_SH_RD:
            begin
                if (idx_reg > lo_reg)
                    state_next = S_SH_WR;
                else
                    state_next = S_PUT;
            end
            S_SH_WR: state_next = S_SH_RD;
            S_PUT:   state_next = S_DONE;
            S_CLR:
            begin
                if (idx_reg >= count_reg)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (load_out)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath and memory controls
    always_comb
    begin
        count_next      = count_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        idx_next        = idx_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        out_valid_next  = out_valid_reg;
        raddr           = mid_reg[IW-1:0];
        kwe             = 1'b0;
        kwaddr          = idx_reg[IW-1:0];
        kwdata          = rdata_reg;
        dwe             = 1'b0;
        dwaddr          = idx_reg[IW-1:0];
        dwdata          = '0;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (load_out)
            out_valid_next = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                lo_next         = '0;
                hi_next         = count_reg;
                idx_next        = '0;
                res_status_next = ST_BULK;
                res_slot_next   = '0;
                if (accept && (op_t'(operation) == OP_EMPTY))
                    count_next = '0;
            end
            S_RD:
            begin
                // issue the read of the middle entry
                mid_next = mid_calc;
                raddr    = mid_calc[IW-1:0];
                idx_next = count_reg;
                if (!(lo_reg < hi_reg) && (count_reg >= FULL_COUNT))
                begin
                    res_status_next = ST_FULL;
                    res_slot_next   = '0;
                end
            end
            S_CMP:
            begin
                if (key_reg < rkey)
                    hi_next = mid_reg;
                else if (key_reg > rkey)
                    lo_next = mid_reg + 1'b1;
                else
                begin
                    // hit: refresh the slot
                    dwe             = 1'b1;
                    dwaddr          = rslot;
                    dwdata          = data_reg;
                    res_status_next = ST_UPDATED;
                    res_slot_next   = CW'(rslot);
                end
            end
            S_SH_RD:
            begin
                raddr = IW'(idx_reg - 1'b1);
            end
            S_SH_WR:
            begin
                // move the entry below up by one
                kwe      = 1'b1;
                kwaddr   = idx_reg[IW-1:0];
                kwdata   = rdata_reg;
                idx_next = idx_reg - 1'b1;
            end
            S_PUT:
            begin
                kwe             = 1'b1;
                kwaddr          = lo_reg[IW-1:0];
                kwdata          = {key_reg, count_reg[IW-1:0]};
                dwe             = 1'b1;
                dwaddr          = count_reg[IW-1:0];
                dwdata          = data_reg;
                count_next      = count_reg + 1'b1;
                res_status_next = ST_INSERTED;
                res_slot_next   = count_reg;
            end
            S_CLR:
            begin
                // zero one held slot per cycle
                if (idx_reg < count_reg)
                begin
                    dwe      = 1'b1;
                    dwaddr   = idx_reg[IW-1:0];
                    dwdata   = '0;
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign slot        = out_slot_reg;
    assign entry_total = out_total_reg;

endmodule

@@ hdl/skst_checker.sv @@
module skst_checker
    import skst_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input logic [1:0]          status,
    input logic [SLOT_W-1:0]   slot,
    input logic [TOTAL_W-1:0]  entry_total
);

    logic [TOTAL_W-1:0] total_less_one;
    assign total_less_one = entry_total - 1'b1;

    // one item in flight at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken while an item is in flight");

    // a new key gets the slot numbered by the count before it
    a_insert_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == ST_INSERTED)) |-> (slot == total_less_one[SLOT_W-1:0]))
        else $error("inserted slot does not match entry total");

    // bulk and dropped items carry slot zero
    a_zero_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && ((status == ST_BULK) || (status == ST_FULL))) |-> (slot == '0))
        else $error("nonzero slot on bulk or dropped item");

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(status) && $stable(slot) && $stable(entry_total)))
        else $error("stalled result changed");

endmodule

bind sorted_key_table_stable_slots skst_checker u_skst_checker (.*);

@@ verif/tb_sorted_key_table_stable_slots.sv @@
module tb_sorted_key_table_stable_slots;
    import skst_pkg::*;

    localparam int NUM_KEYS = 256;
    localparam int KEY_W    = 48;

    // Expected result of one item
    typedef struct {
        status_t            status;
        logic [SLOT_W-1:0]  slot;
        logic [TOTAL_W-1:0] entry_total;
    } table_result_t;

    // Scoreboard: keeps its own copy of the table and the queue of expected results
    class table_scoreboard;
        logic [KEY_W-1:0]    keys_sorted [NUM_KEYS];
        logic [SLOT_W-1:0]   slot_of_key [NUM_KEYS];
        logic [RIDX_W-1:0]   slot_ridx [NUM_KEYS];
        logic [HANDLE_W-1:0] slot_handle [NUM_KEYS];
        int                  held;
        table_result_t       pending [$];
        int                  mismatches;
        int                  checked;

        function void clear();
            held = 0;
            pending.delete();
            mismatches = 0;
            checked = 0;
        endfunction

        // Work out the answer to an accepted item and queue it
        function void note_item(op_t op, logic [KEY_W-1:0] k,
                                logic [HANDLE_W-1:0] h, logic [RIDX_W-1:0] ri);
            table_result_t r;
            int lo;
            int hi;
            int mid;
            bit found;
            lo = 0;
            hi = held;
            found = 0;
            r.slot = '0;
            r.status = ST_BULK;
            if (op == OP_FIND_ADD) begin
                while (lo < hi && !found) begin
                    mid = lo + (hi - lo) / 2;
                    if (k < keys_sorted[mid]) hi = mid;
                    else if (k > keys_sorted[mid]) lo = mid + 1;
                    else found = 1;
                end
                if (found) begin
                    r.status = ST_UPDATED;
                    r.slot = slot_of_key[mid];
                    slot_ridx[slot_of_key[mid]] = ri;
                    slot_handle[slot_of_key[mid]] = h;
                end
                else if (held >= NUM_KEYS) begin
                    r.status = ST_FULL;
                end
                else begin
                    for (int i = held; i > lo; i--) begin
                        keys_sorted[i] = keys_sorted[i-1];
                        slot_of_key[i] = slot_of_key[i-1];
                    end
                    keys_sorted[lo] = k;
                    slot_of_key[lo] = SLOT_W'(held);
                    slot_ridx[held] = ri;
                    slot_handle[held] = h;
                    r.status = ST_INSERTED;
                    r.slot = SLOT_W'(held);
                    held++;
                end
            end
            else if (op == OP_DEACTIVATE) begin
                for (int i = 0; i < held; i++) begin
                    slot_ridx[i] = '0;
                    slot_handle[i] = '0;
                end
            end
            else if (op == OP_EMPTY) begin
                held = 0;
            end
            r.entry_total = TOTAL_W'(held);
            pending.push_back(r);
        endfunction

        task report_mismatch(string what, longint exp_v, longint got_v);
            mismatches++;
            $display("MISMATCH %s: expected %0d got %0d (result %0d)",
                     what, exp_v, got_v, checked);
        endtask

        // Compare one result with the oldest expectation
        task check_result(logic [1:0] st, logic [SLOT_W-1:0] sl,
                          logic [TOTAL_W-1:0] tot);
            table_result_t e;
            checked++;
            if (pending.size() == 0) begin
                report_mismatch("result with nothing expected", 0, st);
                return;
            end
            e = pending.pop_front();
            if (st !== e.status) report_mismatch("status", e.status, st);
            if (sl !== e.slot) report_mismatch("slot", e.slot, sl);
            if (tot !== e.entry_total) report_mismatch("entry_total", e.entry_total, tot);
        endtask
    endclass

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [1:0]          operation;
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] function_handle;
    logic [RIDX_W-1:0]   run_index;
    logic                out_valid;
    logic                out_ready;
    logic [1:0]          status;
    logic [SLOT_W-1:0]   slot;
    logic [TOTAL_W-1:0]  entry_total;

    table_scoreboard     sb;
    int                  send_idle_pct;
    int                  recv_idle_pct;
    int                  items_sent;
    logic [KEY_W-1:0]    key_pool [32];

    sorted_key_table_stable_slots #(.MAX_ENTRIES(NUM_KEYS), .KEY_BITS(KEY_W)) u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .operation(operation), .key(key),
        .function_handle(function_handle), .run_index(run_index),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .slot(slot), .entry_total(entry_total)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Result side: stall at random, check on each accepted result
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (out_valid && out_ready)
                sb.check_result(status, slot, entry_total);
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Offer one item, idling first at random, and hold it until accepted
    task automatic send_item(op_t op, logic [KEY_W-1:0] k,
                             logic [HANDLE_W-1:0] h, logic [RIDX_W-1:0] ri);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        operation <= op;
        key <= k;
        function_handle <= h;
        run_index <= ri;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_item(op, k, h, ri);
        items_sent++;
    endtask

    function automatic logic [47:0] rand48();
        logic [63:0] v;
        v = {$urandom(), $urandom()};
        return v[63:16];
    endfunction

    // Mostly find-or-add on a small pool of keys so hits are common
    task automatic random_item();
        int pick;
        logic [KEY_W-1:0] k;
        pick = $urandom_range(99);
        if (pick < 60) k = key_pool[$urandom_range(31)];
        else k = rand48();
        if (pick < 88)
            send_item(OP_FIND_ADD, k, rand48(), 16'($urandom()));
        else if (pick < 93)
            send_item(OP_DEACTIVATE, rand48(), rand48(), 16'($urandom()));
        else if (pick < 96)
            send_item(OP_EMPTY, rand48(), rand48(), 16'($urandom()));
        else
            send_item(OP_NONE, k, rand48(), 16'($urandom()));
    endtask

    initial
    begin
        #30000000;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        int wait_cycles;
        sb = new();
        sb.clear();
        items_sent = 0;
        send_idle_pct = 8;
        recv_idle_pct = 63;
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        operation = OP_FIND_ADD;
        key = '0;
        function_handle = '0;
        run_index = '0;
        for (int i = 0; i < 32; i++)
            key_pool[i] = rand48();
        key_pool[0] = '0;
        key_pool[1] = '1;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, hits, every operation
        send_item(OP_FIND_ADD, 48'd1000, '1, '1);
        send_item(OP_FIND_ADD, '0, '0, '0);
        send_item(OP_FIND_ADD, '1, 48'hAAAA_AAAA_AAAA, 16'h5555);
        send_item(OP_FIND_ADD, 48'd500, 48'h5555_5555_5555, 16'hAAAA);
        send_item(OP_FIND_ADD, 48'd1000, 48'd7, 16'd9);
        send_item(OP_FIND_ADD, '0, 48'd1, 16'd1);
        send_item(OP_FIND_ADD, '1, 48'd2, 16'd2);
        send_item(OP_DEACTIVATE, '1, '1, '1);
        send_item(OP_FIND_ADD, 48'd500, 48'd3, 16'd3);
        send_item(OP_NONE, 48'd77, '1, '1);
        send_item(OP_EMPTY, '1, '1, '1);
        send_item(OP_FIND_ADD, 48'd500, 48'd4, 16'd4);
        send_item(OP_EMPTY, '0, '0, '0);

        // Fill the table with descending keys, then overflow and hit
        for (int i = 0; i < NUM_KEYS; i++)
            send_item(OP_FIND_ADD, 48'(4000 - 8 * i), rand48(), 16'($urandom()));
        send_item(OP_FIND_ADD, 48'd3, rand48(), 16'($urandom()));
        send_item(OP_FIND_ADD, '1, rand48(), 16'($urandom()));
        send_item(OP_FIND_ADD, 48'd4000, rand48(), 16'($urandom()));
        send_item(OP_FIND_ADD, 48'(4000 - 8 * 255), rand48(), 16'($urandom()));
        send_item(OP_DEACTIVATE, '0, '0, '0);
        send_item(OP_EMPTY, '0, '0, '0);

        // Random phases with the idling swapped round, then with no idling at all
        for (int ph = 0; ph < 3; ph++) begin
            if (ph == 1) begin
                send_idle_pct = 63;
                recv_idle_pct = 8;
            end
            else if (ph == 2) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (int n = 0; n < 280; n++)
                random_item();
        end
        in_valid <= 1'b0;

        wait_cycles = 0;
        while (sb.pending.size() != 0 && wait_cycles < 200000) begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (600) @(posedge clk);

        $display("Covered %0d items, %0d results checked: inserts, hits, full table,",
                 items_sent, sb.checked);
        $display("deactivate, empty and the unused operation under three stall patterns.");
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("Regression PASS");
        end
        else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
